/* sv/assert_macros.svh */
// assertion helpers used by the rtl queue file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on the rising clock edge, off while reset is high
`define ASSERT_CHECK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  `ASSERT_CHECK(label, clk, rst, (ante) |-> (cons))

`endif

/* sv/qtse_pkg.sv */
// ----------------------------------------------------------------------------
// qtse_pkg
// types and character codes shared by the token splitter modules
// ----------------------------------------------------------------------------
`default_nettype none

package qtse_pkg;

  localparam int MaxRes = 6;
  localparam int CntW   = $clog2(MaxRes + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D7     = 8'h37;
  localparam logic [7:0] CH_D8     = 8'h38;
  localparam logic [7:0] CH_D9     = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LOWF   = 8'h66;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_HEX1 = 3'd2,
    PH_HEX2 = 3'd3,
    PH_OCT2 = 3'd4,
    PH_OCT3 = 3'd5
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_ent_t;

  typedef struct packed {
    logic [CntW-1:0]           count;
    res_ent_t [MaxRes-1:0]     ent;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

/* sv/qtse_front.sv */
// ----------------------------------------------------------------------------
// qtse_front
// accepts input words, runs the quoting and escape state and builds one
// bundle of results per word
// ----------------------------------------------------------------------------
`default_nettype none

module qtse_front
  import qtse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       line_end,
  input  wire q_stat_t    q_stat,
  output logic            push,
  output bundle_t         push_data
);

  logic       token_open, token_open_next;
  logic       quoting, quoting_next;
  phase_t     phase, phase_next;
  logic [7:0] held0, held0_next;
  logic [7:0] held1, held1_next;

  logic            accept;
  logic            do_bail, do_plain, do_fin;
  logic [7:0]      fin_val;
  logic [1:0]      feed_cnt, end_cnt;
  logic [CntW-1:0] n;
  bundle_t         bund;
  logic            is_blank;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= CH_D0 && b <= CH_D9) || (b >= CH_LA && b <= CH_LOWF) ||
           (b >= CH_UA && b <= CH_UF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b >= CH_D0 && b <= CH_D9) v = b - CH_D0;
    else if (b >= CH_LA && b <= CH_LOWF) v = b - CH_LA + 8'd10;
    else v = b - CH_UA + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic is_oct(input logic [7:0] b);
    return b >= CH_D0 && b <= CH_D7;
  endfunction

  function automatic logic [1:0] held_cnt(input phase_t p);
    logic [1:0] c;
    unique case (p)
      PH_HEX1, PH_OCT2: c = 2'd1;
      PH_HEX2, PH_OCT3: c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_NL);

  always_comb begin
    token_open_next = token_open;
    quoting_next    = quoting;
    phase_next      = phase;
    held0_next      = held0;
    held1_next      = held1;
    do_bail         = 1'b0;
    do_plain        = 1'b0;
    do_fin          = 1'b0;
    fin_val         = in_byte;
    feed_cnt        = held_cnt(phase);
    end_cnt         = 2'd0;
    n               = '0;
    bund            = '0;

    // decode step for the pending escape
    unique case (phase)
      PH_ESC: begin
        priority if (in_byte == CH_LA) begin
          do_fin = 1'b1; fin_val = CH_BEL;
        end else if (in_byte == CH_LB) begin
          do_fin = 1'b1; fin_val = CH_BS;
        end else if (in_byte == CH_LF) begin
          do_fin = 1'b1; fin_val = CH_FF;
        end else if (in_byte == CH_LN) begin
          do_fin = 1'b1; fin_val = CH_NL;
        end else if (in_byte == CH_LR) begin
          do_fin = 1'b1; fin_val = CH_CR;
        end else if (in_byte == CH_LT) begin
          do_fin = 1'b1; fin_val = CH_TAB;
        end else if (in_byte == CH_LX) begin
          held0_next = in_byte; phase_next = PH_HEX1;
        end else if (in_byte == CH_D8 || in_byte == CH_D9) begin
          do_bail = 1'b1; do_plain = 1'b1;
        end else if (is_oct(in_byte)) begin
          held0_next = in_byte; phase_next = PH_OCT2;
        end else begin
          do_fin = 1'b1;
        end
      end
      PH_HEX1: begin
        if (is_hex(in_byte)) begin
          held1_next = in_byte; phase_next = PH_HEX2;
        end else begin
          do_bail = 1'b1; do_plain = 1'b1;
        end
      end
      PH_HEX2: begin
        if (is_hex(in_byte)) begin
          do_fin = 1'b1; fin_val = {hex_val(held1), hex_val(in_byte)};
        end else begin
          do_bail = 1'b1; do_plain = 1'b1;
        end
      end
      PH_OCT2: begin
        if (is_oct(in_byte)) begin
          held1_next = in_byte; phase_next = PH_OCT3;
        end else begin
          do_bail = 1'b1; do_plain = 1'b1;
        end
      end
      PH_OCT3: begin
        if (is_oct(in_byte)) begin
          do_fin = 1'b1; fin_val = {held0[1:0], held1[2:0], in_byte[2:0]};
        end else begin
          do_bail = 1'b1; do_plain = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        do_plain   = 1'b1;
      end
    endcase

    // malformed escape: literal backslash then held bytes
    if (do_bail) begin
      bund.ent[n] = '{kind: KIND_BYTE, data: CH_BSLASH}; n = n + 1'b1;
      if (feed_cnt != 2'd0) begin
        bund.ent[n] = '{kind: KIND_BYTE, data: held0}; n = n + 1'b1;
      end
      if (feed_cnt == 2'd2) begin
        bund.ent[n] = '{kind: KIND_BYTE, data: held1}; n = n + 1'b1;
      end
      token_open_next = 1'b1;
      phase_next      = PH_IDLE;
    end

    if (do_fin) begin
      bund.ent[n] = '{kind: KIND_BYTE, data: fin_val}; n = n + 1'b1;
      token_open_next = 1'b1;
      phase_next      = PH_IDLE;
    end

    if (do_plain) begin
      priority if (in_byte == CH_BSLASH) begin
        phase_next = PH_ESC;
      end else if (is_blank && !quoting_next) begin
        if (token_open_next) begin
          bund.ent[n] = '{kind: KIND_TOKEN_END, data: 8'h00}; n = n + 1'b1;
          token_open_next = 1'b0;
        end
      end else begin
        if (in_byte == CH_QUOTE) quoting_next = !quoting_next;
        bund.ent[n] = '{kind: KIND_BYTE, data: in_byte}; n = n + 1'b1;
        token_open_next = 1'b1;
      end
    end

    // line end closes everything
    if (line_end) begin
      end_cnt = held_cnt(phase_next);
      if (phase_next != PH_IDLE) begin
        bund.ent[n] = '{kind: KIND_BYTE, data: CH_BSLASH}; n = n + 1'b1;
        if (end_cnt != 2'd0) begin
          bund.ent[n] = '{kind: KIND_BYTE, data: held0_next}; n = n + 1'b1;
        end
        if (end_cnt == 2'd2) begin
          bund.ent[n] = '{kind: KIND_BYTE, data: held1_next}; n = n + 1'b1;
        end
        token_open_next = 1'b1;
      end
      phase_next = PH_IDLE;
      if (token_open_next) begin
        bund.ent[n] = '{kind: KIND_TOKEN_END, data: 8'h00}; n = n + 1'b1;
      end
      bund.ent[n] = '{kind: KIND_LINE_END, data: 8'h00}; n = n + 1'b1;
      token_open_next = 1'b0;
      quoting_next    = 1'b0;
    end

    bund.count = n;
  end

  assign push      = accept && (n != '0);
  assign push_data = bund;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_open <= 1'b0;
      quoting    <= 1'b0;
      phase      <= PH_IDLE;
    end else if (accept) begin
      token_open <= token_open_next;
      quoting    <= quoting_next;
      phase      <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

endmodule

`default_nettype wire

/* sv/qtse_queue.sv */
// ----------------------------------------------------------------------------
// qtse_queue
// two-entry bundle queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qtse_queue
  import qtse_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  input  wire logic    pop,
  output bundle_t      head,
  output q_stat_t      q_stat
);

  bundle_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_stat.empty = (count == 2'd0);
  assign q_stat.full  = (count == 2'd2);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_IMPLIES(a_no_push_full, clk, rst, q_stat.full, !push)
  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst, q_stat.empty, !pop)
  `ASSERT_IMPLIES(a_ptr_match, clk, rst, count != 2'd1, wr_ptr == rd_ptr)

endmodule

`default_nettype wire

/* sv/qtse_back.sv */
// ----------------------------------------------------------------------------
// qtse_back
// walks the head bundle and sends its results out one word per cycle while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module qtse_back
  import qtse_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t head,
  input  wire q_stat_t q_stat,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [1:0]   kind,
  output logic [7:0]   out_byte,
  output logic         last
);

  logic [CntW-1:0] idx;
  res_ent_t        cur;

  assign cur       = head.ent[idx];
  assign out_valid = !q_stat.empty;
  assign kind      = cur.kind;
  assign out_byte  = cur.data;
  assign last      = (idx == head.count - 1'b1);
  assign pop       = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* sv/quoted_token_splitter_with_escapes_unit.sv */
// ----------------------------------------------------------------------------
// quoted_token_splitter_with_escapes_unit
// splits a command line into tokens with quoting and c escape decoding
//
//   channel | signals                                | dir
//   input   | in_valid in_ready in_byte line_end     | in
//   output  | out_valid out_ready kind out_byte last | out
//
// an input word is taken while in_ready is high and yields up to six results
// results leave one per cycle while out_ready is high
// throughput is set by the one-result-per-cycle output serializer
// a two-entry bundle queue lets input continue while the output stalls, until it fills
// synchronous reset clears the parse state and the queue, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_token_splitter_with_escapes_unit
  import qtse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       line_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic            last
);

  logic    push;
  logic    pop;
  bundle_t push_data;
  bundle_t head;
  q_stat_t q_stat;

  qtse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .line_end  (line_end),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  qtse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  qtse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks the quoted token splitter against a cycle-free predictor
//
// words go in on a valid/ready channel with random gaps, results come out on
// a second valid/ready channel with random stalls. a scoreboard class predicts
// the result words of each accepted input word (token bytes, token ends, line
// ends, escape decoding and the fallback on malformed escapes) and compares
// every accepted result field by field with the oldest prediction. stimulus
// is a short directed set of lines followed by random command lines built
// mostly from tokens, blanks, quotes and escapes, with some raw noise.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qtse_pkg::*;

  localparam int IdleLimit  = 4000;
  localparam int HoldCycles = 200;
  localparam int PhaseWords = 100;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } token_result_t;

  class token_scoreboard;
    token_result_t expected_results[$];
    logic          tok_open;
    logic          in_quote;
    phase_t        esc_phase;
    logic [7:0]    held[3];
    int            held_n;
    int            fails;
    int            words;
    int            lines;
    int            results;

    function new();
      tok_open  = 1'b0;
      in_quote  = 1'b0;
      esc_phase = PH_IDLE;
      held_n    = 0;
      fails     = 0;
      words     = 0;
      lines     = 0;
      results   = 0;
      foreach (held[i]) held[i] = 8'h00;
    endfunction

    function void push_result(kind_t k, logic [7:0] d);
      expected_results.push_back('{k, d, 1'b0});
    endfunction

    function void token_byte(logic [7:0] d);
      push_result(KIND_BYTE, d);
      tok_open = 1'b1;
    endfunction

    function bit is_hex(logic [7:0] b);
      return (b >= CH_D0 && b <= CH_D9) || (b >= CH_LA && b <= CH_LOWF) ||
             (b >= CH_UA && b <= CH_UF);
    endfunction

    function bit is_oct(logic [7:0] b);
      return b >= CH_D0 && b <= CH_D7;
    endfunction

    function int hex_value(logic [7:0] b);
      if (b >= CH_D0 && b <= CH_D9) return b - CH_D0;
      if (b >= CH_LA && b <= CH_LOWF) return b - CH_LA + 10;
      return b - CH_UA + 10;
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == CH_BSLASH) begin
        esc_phase = PH_ESC;
        held_n    = 0;
      end else if ((b == CH_SPACE || b == CH_TAB || b == CH_NL) && !in_quote) begin
        if (tok_open) push_result(KIND_TOKEN_END, 8'h00);
        tok_open = 1'b0;
      end else begin
        if (b == CH_QUOTE) in_quote = !in_quote;
        token_byte(b);
      end
    endfunction

    // literal backslash plus the held bytes
    function void flush_escape();
      token_byte(CH_BSLASH);
      for (int i = 0; i < held_n; i++) token_byte(held[i]);
      held_n    = 0;
      esc_phase = PH_IDLE;
    endfunction

    function void close_escape(logic [7:0] v);
      token_byte(v);
      esc_phase = PH_IDLE;
      held_n    = 0;
    endfunction

    function void feed(logic [7:0] b);
      int v;
      case (esc_phase)
        PH_ESC: begin
          case (b)
            CH_LA: close_escape(CH_BEL);
            CH_LB: close_escape(CH_BS);
            CH_LF: close_escape(CH_FF);
            CH_LN: close_escape(CH_NL);
            CH_LR: close_escape(CH_CR);
            CH_LT: close_escape(CH_TAB);
            CH_LX: begin
              held[0]   = b;
              held_n    = 1;
              esc_phase = PH_HEX1;
            end
            CH_D8, CH_D9: begin
              flush_escape();
              plain_byte(b);
            end
            default: begin
              if (is_oct(b)) begin
                held[0]   = b;
                held_n    = 1;
                esc_phase = PH_OCT2;
              end else begin
                close_escape(b);
              end
            end
          endcase
        end
        PH_HEX1: begin
          if (is_hex(b)) begin
            held[1]   = b;
            held_n    = 2;
            esc_phase = PH_HEX2;
          end else begin
            flush_escape();
            plain_byte(b);
          end
        end
        PH_HEX2: begin
          if (is_hex(b)) begin
            v = hex_value(held[1]) * 16 + hex_value(b);
            close_escape(v[7:0]);
          end else begin
            flush_escape();
            plain_byte(b);
          end
        end
        PH_OCT2: begin
          if (is_oct(b)) begin
            held[1]   = b;
            held_n    = 2;
            esc_phase = PH_OCT3;
          end else begin
            flush_escape();
            plain_byte(b);
          end
        end
        PH_OCT3: begin
          if (is_oct(b)) begin
            v = (held[0] - CH_D0) * 64 + (held[1] - CH_D0) * 8 + (b - CH_D0);
            close_escape(v[7:0]);
          end else begin
            flush_escape();
            plain_byte(b);
          end
        end
        default: begin
          esc_phase = PH_IDLE;
          held_n    = 0;
          plain_byte(b);
        end
      endcase
    endfunction

    function void note_word(logic [7:0] b, logic e);
      int first;
      first = expected_results.size();
      words++;
      feed(b);
      if (e) begin
        if (esc_phase != PH_IDLE) flush_escape();
        esc_phase = PH_IDLE;
        held_n    = 0;
        if (tok_open) push_result(KIND_TOKEN_END, 8'h00);
        push_result(KIND_LINE_END, 8'h00);
        tok_open = 1'b0;
        in_quote = 1'b0;
        lines++;
      end
      if (expected_results.size() > first)
        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 40) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task check_result(logic [1:0] k, logic [7:0] d, logic l);
      token_result_t exp;
      results++;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h last %0b", k, d, l));
        return;
      end
      exp = expected_results.pop_front();
      if (k !== exp.kind)
        report($sformatf("result %0d kind %0d, want %0d", results, k, exp.kind));
      if (d !== exp.data)
        report($sformatf("result %0d byte %02h, want %02h", results, d, exp.data));
      if (l !== exp.last)
        report($sformatf("result %0d last %0b, want %0b", results, l, exp.last));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       line_end;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;

  token_scoreboard sb = new();

  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         words_sent     = 0;
  int         idle_cycles    = 0;
  bit         hold_req       = 1'b0;
  bit         hold_done      = 1'b0;
  int         hold_left      = 0;
  logic [7:0] line_q[$];

  quoted_token_splitter_with_escapes_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .line_end  (line_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .last      (last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(in_byte, line_end);
      if (out_valid && out_ready) sb.check_result(kind, out_byte, last);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver side, long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic e);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    line_end <= e;
    words_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_word(line_q[i], i == line_q.size() - 1);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void add_escape_piece(int sel);
    string hexd    = "0123456789abcdefABCDEF";
    string octd    = "01234567";
    string non_hex = "ghkmpqsuwzGHKZ_ \t\n\"\\";
    string non_oct = "89abxyz_ \t\n\"\\";
    line_q.push_back(CH_BSLASH);
    case (sel)
      0: begin
        if ($urandom_range(0, 3) == 0) line_q.push_back(8'($urandom_range(1, 255)));
        else line_q.push_back(pick("abfnrtvq? \"\\"));
      end
      1: begin
        line_q.push_back(CH_LX);
        line_q.push_back(pick(hexd));
        line_q.push_back(pick(hexd));
      end
      2: begin
        line_q.push_back(CH_LX);
        if ($urandom_range(0, 1)) line_q.push_back(pick(hexd));
        line_q.push_back(pick(non_hex));
      end
      3: begin
        line_q.push_back(pick(octd));
        line_q.push_back(pick(octd));
        line_q.push_back(pick(octd));
      end
      default: begin
        if ($urandom_range(0, 2) == 0) begin
          line_q.push_back(pick("89"));
        end else begin
          line_q.push_back(pick(octd));
          if ($urandom_range(0, 1)) line_q.push_back(pick(octd));
          line_q.push_back(pick(non_oct));
        end
      end
    endcase
  endfunction

  function automatic void build_line();
    int n;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) line_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: repeat ($urandom_range(1, 4))
          line_q.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFXYZ0123456789_-./="));
        4:  repeat ($urandom_range(1, 3)) line_q.push_back(pick(" \t\n"));
        5:  line_q.push_back(CH_QUOTE);
        6:  add_escape_piece(0);
        7:  add_escape_piece($urandom_range(1, 2));
        8:  add_escape_piece(3);
        9:  add_escape_piece(4);
        default: line_q.push_back(8'($urandom_range(1, 255)));
      endcase
    end
    // escape cut short by the line end
    if ($urandom_range(0, 7) == 0) begin
      line_q.push_back(CH_BSLASH);
      case ($urandom_range(0, 2))
        0: ;
        1: begin
          line_q.push_back(CH_LX);
          if ($urandom_range(0, 1)) line_q.push_back(pick("09afAF"));
        end
        default: begin
          line_q.push_back(pick("01234567"));
          if ($urandom_range(0, 1)) line_q.push_back(pick("01234567"));
        end
      endcase
    end
  endfunction

  task automatic run_phase(int idle_pct, int stall_pct, int target);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (words_sent < target) begin
      build_line();
      send_line();
    end
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    line_end = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    hold_req = 1'b1;
    line_q = '{"a", CH_TAB, CH_QUOTE, CH_SPACE, CH_QUOTE, CH_BSLASH, "x", "F", "f",
               CH_BSLASH, "x", "Z", CH_BSLASH, "7", "7", "7", CH_BSLASH, "1", "8",
               CH_BSLASH, "9", CH_NL, 8'hFF, CH_BSLASH};
    send_line();
    line_q = '{CH_BSLASH, "b", CH_BSLASH, CH_QUOTE, CH_BSLASH, "r", 8'h01};
    send_line();

    run_phase(0, 0, words_sent + PhaseWords);
    run_phase(86, 0, words_sent + PhaseWords);
    run_phase(0, 86, words_sent + PhaseWords);
    run_phase(18, 18, words_sent + PhaseWords);

    @(negedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d words in %0d lines, %0d results checked, %0d mismatches",
             sb.words, sb.lines, sb.results, sb.fails);
    $display("flow phases: free, sender gaps, receiver stalls, both; %0d-cycle hold-off",
             HoldCycles);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/qtse_pkg.sv
sv/qtse_front.sv
sv/qtse_queue.sv
sv/qtse_back.sv
sv/quoted_token_splitter_with_escapes_unit.sv
sim/testbench.sv
